FILE: rtl/core/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg
// Shared constants and types of the ATA PIO LBA28 disk device.
// ----------------------------------------------------------------------------
package ata_pkg;

    localparam int DISK_SECTORS = 64;
    localparam int SECTOR_WORDS = 256;
    localparam int STORE_WORDS  = DISK_SECTORS * SECTOR_WORDS;
    localparam int SEC_AW       = (DISK_SECTORS > 1) ? $clog2(DISK_SECTORS) : 1;
    localparam int WORD_AW      = $clog2(SECTOR_WORDS);
    localparam int STORE_AW     = SEC_AW + WORD_AW;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = 8;

    typedef logic [STORE_AW-1:0] store_addr_t;

    typedef struct packed {
        logic        we;
        logic        re;
        store_addr_t addr;
        logic [15:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic        valid;
        logic        from_mem;
        logic [15:0] rd;
        logic        drq;
        logic        err;
    } stage_t;

    typedef struct packed {
        logic idle;
        logic wi_zero;
        logic drq;
        logic err;
    } tf_status_t;

endpackage

FILE: rtl/core/ata_pio_lba28_disk_device_unit.sv
// ----------------------------------------------------------------------------
// ata_pio_lba28_disk_device_unit
// Primary ATA disk seen through its taskfile ports, one bus access per item.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: write_data; tuser: opcode, reg_offset
//   m_*      out  m_tvalid/m_tready  tdata: read_data, data_request, error_flag
//   cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// One item per cycle sustained while results are taken; each item passes the
// first result stage (with the registered sector store read), then the output
// register. Input stays ready while a result waits, up to one more item.
// Reset clears the taskfile and control state; the store is not cleared.
// ----------------------------------------------------------------------------
module ata_pio_lba28_disk_device_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] write_data
    input  logic [4:0]                    s_tuser,   // [0] opcode, [4:1] reg_offset
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [15:0] read_data, [16] data_request,
                                                     // [17] error_flag, [23:18] zero
    input  logic                          cfg_we,
    input  logic [ata_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ata_pkg::CFG_W-1:0]     cfg_wdata
);
    import ata_pkg::*;

    stage_t     stage;
    mem_req_t   mem_req;
    tf_status_t status;
    logic [15:0] mem_q;
    logic        a_take;

    ata_taskfile u_taskfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_wr     (s_tuser[0]),
        .in_off    (s_tuser[4:1]),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .a_take    (a_take),
        .stage     (stage),
        .mem_req   (mem_req),
        .status    (status)
    );

    ata_store u_store (
        .clk (clk),
        .req (mem_req),
        .q   (mem_q)
    );

    ata_outreg u_outreg (
        .clk     (clk),
        .rst_n   (rst_n),
        .a       (stage),
        .mem_q   (mem_q),
        .a_take  (a_take),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

    a_drq_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        status.drq |-> !status.idle)
        else $error("DRQ set while idle");

    a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        status.idle |-> status.wi_zero)
        else $error("word index not cleared in idle");

    a_err_no_drq: assert property (@(posedge clk) disable iff (!rst_n)
        status.err |-> !status.drq)
        else $error("ERR and DRQ both set");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && stage.valid))
        else $error("input stalled with free result slot");

endmodule

FILE: rtl/core/ata_store.sv
// ----------------------------------------------------------------------------
// ata_store
// Sector store: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ata_store (
    input  logic              clk,
    input  ata_pkg::mem_req_t req,
    output logic [15:0]       q
);
    import ata_pkg::*;

    logic [15:0] mem [STORE_WORDS];
    logic [15:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            q_reg <= mem[req.addr];
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/core/ata_taskfile.sv
// ----------------------------------------------------------------------------
// ata_taskfile
// Taskfile registers, command decode and transfer control; one bus access
// per cycle into the first result stage while that stage is free or taken.
// ----------------------------------------------------------------------------
module ata_taskfile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_wr,
    input  logic [3:0]                    in_off,
    input  logic [15:0]                   in_data,
    input  logic                          cfg_we,
    input  logic [ata_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ata_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          a_take,
    output ata_pkg::stage_t               stage,
    output ata_pkg::mem_req_t             mem_req,
    output ata_pkg::tf_status_t           status
);
    import ata_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_READ,
        MODE_WRITE,
        MODE_IDENT
    } mode_t;

    localparam logic [3:0] OFF_DATA   = 4'd0;
    localparam logic [3:0] OFF_COUNT  = 4'd2;
    localparam logic [3:0] OFF_LBA0   = 4'd3;
    localparam logic [3:0] OFF_LBA1   = 4'd4;
    localparam logic [3:0] OFF_LBA2   = 4'd5;
    localparam logic [3:0] OFF_SELECT = 4'd6;
    localparam logic [3:0] OFF_CMD    = 4'd7;
    localparam logic [3:0] OFF_ALT    = 4'd8;

    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;
    localparam logic [7:0] CMD_IDENT = 8'hEC;

    localparam logic [CFG_IDX_W-1:0] CFG_CYL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 2'd2;

    localparam logic [7:0] STATUS_RDY = 8'h40;
    localparam logic [7:0] SEL_RESET  = 8'hE0;

    logic [7:0]  sc_reg, sc_next;
    logic [27:0] lba_reg, lba_next;
    logic [7:0]  sel_reg, sel_next;
    mode_t       mode_reg, mode_next;
    logic [8:0]  left_reg, left_next;
    logic [7:0]  wi_reg, wi_next;
    logic        drq_reg, drq_next;
    logic        err_reg, err_next;
    logic [7:0]  cyl_reg, heads_reg, spt_reg;
    stage_t      stage_reg, stage_next;

    logic        accept;
    logic [7:0]  wbyte;
    logic [8:0]  count;
    logic        fits;
    logic        in_store;
    logic        advance;
    logic        idle_req;
    logic        idle_err;
    logic [8:0]  left_dec;
    logic [7:0]  status_byte;
    logic        start_rw;
    mode_t       start_mode;

    function automatic logic [15:0] ident_word(input logic [7:0] idx, input logic [7:0] cyl,
                                               input logic [7:0] heads, input logic [7:0] spt);
        logic [15:0] w;
        w = 16'h0000;
        case (idx)
            8'd1:    w = {8'h00, cyl};
            8'd3:    w = {8'h00, heads};
            8'd6:    w = {8'h00, spt};
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

    assign accept      = in_valid && in_ready;
    assign in_ready    = !stage_reg.valid || a_take;
    assign wbyte       = in_data[7:0];
    assign count       = (sc_reg == 8'd0) ? 9'd256 : {1'b0, sc_reg};
    assign fits        = ({1'b0, lba_reg} + {20'd0, count}) <= 29'(DISK_SECTORS);
    // only LBA bits 23:0 are checked against the disk size, so LBA bits 27:24 drop out
    assign in_store    = lba_reg[23:0] < 24'(DISK_SECTORS);
    assign left_dec    = (left_reg != 9'd0) ? left_reg - 9'd1 : 9'd0;
    assign status_byte = STATUS_RDY | {4'b0000, drq_reg, 2'b00, err_reg};

    always_comb
    begin
        sc_next    = sc_reg;
        lba_next   = lba_reg;
        sel_next   = sel_reg;
        mode_next  = mode_reg;
        left_next  = left_reg;
        wi_next    = wi_reg;
        drq_next   = drq_reg;
        err_next   = err_reg;
        stage_next = stage_reg;
        advance    = 1'b0;
        idle_req   = 1'b0;
        idle_err   = 1'b0;
        start_rw   = 1'b0;
        start_mode = MODE_READ;
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = in_store ? {lba_reg[SEC_AW-1:0], wi_reg} : '0;
        mem_req.wdata = in_data;

        if (a_take)
        begin
            stage_next.valid = 1'b0;
        end

        if (accept)
        begin
            stage_next.valid    = 1'b1;
            stage_next.from_mem = 1'b0;
            stage_next.rd       = 16'h0000;
            if (in_wr)
            begin
                case (in_off)
                    OFF_DATA:
                    begin
                        if (mode_reg == MODE_WRITE && drq_reg)
                        begin
                            mem_req.we = 1'b1;
                            advance    = 1'b1;
                        end
                    end
                    OFF_COUNT:  sc_next = wbyte;
                    OFF_LBA0:   lba_next[7:0] = wbyte;
                    OFF_LBA1:   lba_next[15:8] = wbyte;
                    OFF_LBA2:   lba_next[23:16] = wbyte;
                    OFF_SELECT:
                    begin
                        sel_next         = wbyte;
                        lba_next[27:24]  = wbyte[3:0];
                    end
                    OFF_CMD:
                    begin
                        case (wbyte)
                            CMD_FLUSH:
                            begin
                                if (mode_reg != MODE_WRITE)
                                begin
                                    idle_req = 1'b1;
                                end
                            end
                            CMD_READ:
                            begin
                                start_rw   = 1'b1;
                                start_mode = MODE_READ;
                            end
                            CMD_WRITE:
                            begin
                                start_rw   = 1'b1;
                                start_mode = MODE_WRITE;
                            end
                            CMD_IDENT:
                            begin
                                mode_next = MODE_IDENT;
                                left_next = 9'd1;
                                wi_next   = 8'd0;
                                drq_next  = 1'b1;
                                err_next  = 1'b0;
                            end
                            default:
                            begin
                                idle_req = 1'b1;
                                idle_err = 1'b1;
                            end
                        endcase
                        if (start_rw)
                        begin
                            if (fits)
                            begin
                                mode_next = start_mode;
                                left_next = count;
                                wi_next   = 8'd0;
                                drq_next  = 1'b1;
                                err_next  = 1'b0;
                            end
                            else
                            begin
                                idle_req = 1'b1;
                                idle_err = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (in_off)
                    OFF_DATA:
                    begin
                        if (mode_reg == MODE_READ && drq_reg)
                        begin
                            mem_req.re          = 1'b1;
                            stage_next.from_mem = 1'b1;
                            advance             = 1'b1;
                        end
                        else if (mode_reg == MODE_IDENT && drq_reg)
                        begin
                            stage_next.rd = ident_word(wi_reg, cyl_reg, heads_reg, spt_reg);
                            advance       = 1'b1;
                        end
                    end
                    OFF_COUNT:  stage_next.rd = {8'h00, sc_reg};
                    OFF_LBA0:   stage_next.rd = {8'h00, lba_reg[7:0]};
                    OFF_LBA1:   stage_next.rd = {8'h00, lba_reg[15:8]};
                    OFF_LBA2:   stage_next.rd = {8'h00, lba_reg[23:16]};
                    OFF_SELECT: stage_next.rd = {8'h00, sel_reg};
                    OFF_CMD,
                    OFF_ALT:    stage_next.rd = {8'h00, status_byte};
                    default:    stage_next.rd = 16'h0000;
                endcase
            end

            if (advance)
            begin
                wi_next = wi_reg + 8'd1;
                if (wi_reg == 8'hFF)
                begin
                    if (mode_reg != MODE_IDENT)
                    begin
                        lba_next = lba_reg + 28'd1;
                    end
                    left_next = left_dec;
                    if (left_dec == 9'd0)
                    begin
                        idle_req = 1'b1;
                    end
                end
            end

            if (idle_req)
            begin
                mode_next = MODE_IDLE;
                left_next = 9'd0;
                wi_next   = 8'd0;
                drq_next  = 1'b0;
                err_next  = idle_err;
            end

            stage_next.drq = drq_next;
            stage_next.err = err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg          <= 8'd0;
            lba_reg         <= 28'd0;
            sel_reg         <= SEL_RESET;
            mode_reg        <= MODE_IDLE;
            left_reg        <= 9'd0;
            wi_reg          <= 8'd0;
            drq_reg         <= 1'b0;
            err_reg         <= 1'b0;
            cyl_reg         <= 8'd16;
            heads_reg       <= 8'd4;
            spt_reg         <= 8'd63;
            stage_reg       <= '0;
        end
        else
        begin
            sc_reg          <= sc_next;
            lba_reg         <= lba_next;
            sel_reg         <= sel_next;
            mode_reg        <= mode_next;
            left_reg        <= left_next;
            wi_reg          <= wi_next;
            drq_reg         <= drq_next;
            err_reg         <= err_next;
            stage_reg       <= stage_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CYL:   cyl_reg   <= cfg_wdata;
                    CFG_HEADS: heads_reg <= cfg_wdata;
                    CFG_SPT:   spt_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    assign stage          = stage_reg;
    assign status.idle    = (mode_reg == MODE_IDLE);
    assign status.wi_zero = (wi_reg == 8'd0);
    assign status.drq     = drq_reg;
    assign status.err     = err_reg;

endmodule

FILE: rtl/core/ata_outreg.sv
// ----------------------------------------------------------------------------
// ata_outreg
// Output register: picks store data or register data and holds the result
// item until the downstream side takes it.
// ----------------------------------------------------------------------------
module ata_outreg (
    input  logic            clk,
    input  logic            rst_n,
    input  ata_pkg::stage_t a,
    input  logic [15:0]     mem_q,
    output logic            a_take,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [23:0]     m_data
);
    import ata_pkg::*;

    logic        valid_reg;
    logic [23:0] data_reg;
    logic [15:0] rd_sel;

    assign a_take = a.valid && (!valid_reg || m_ready);
    assign rd_sel = a.from_mem ? mem_q : a.rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (a_take)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            data_reg <= {6'b000000, a.err, a.drq, rd_sel};
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for ata_pio_lba28_disk_device_unit. A behavioral copy of the drive
// (taskfile, transfer state, sector store) predicts the reply to every bus
// access; a checker compares each reply on the output stream, in order, with
// the prediction. Directed taskfile and command cases come first, then
// geometry settings, a full two-sector write, the second read back, an output
// stall that backs up the input, and random command bursts with random data.
// ----------------------------------------------------------------------------
module tb;

    import ata_pkg::*;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam logic [3:0] REG_PIO_WORD   = 4'd0;
    localparam logic [3:0] REG_FEATURES   = 4'd1;
    localparam logic [3:0] REG_COUNT      = 4'd2;
    localparam logic [3:0] REG_LBA_LO     = 4'd3;
    localparam logic [3:0] REG_LBA_BYTE1  = 4'd4;
    localparam logic [3:0] REG_LBA_HI     = 4'd5;
    localparam logic [3:0] REG_SELECT     = 4'd6;
    localparam logic [3:0] REG_CMD_STATUS = 4'd7;
    localparam logic [3:0] REG_ALT_STATUS = 4'd8;
    localparam logic [3:0] REG_UNMAPPED   = 4'd15;

    localparam logic [7:0] CMD_READ    = 8'h20;
    localparam logic [7:0] CMD_WRITE   = 8'h30;
    localparam logic [7:0] CMD_FLUSH   = 8'hE7;
    localparam logic [7:0] CMD_IDENT   = 8'hEC;
    localparam logic [7:0] CMD_UNKNOWN = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_CYLINDERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT       = 2'd2;

    localparam int ID_WORD_CYLINDERS = 1;
    localparam int ID_WORD_HEADS     = 3;
    localparam int ID_WORD_SPT       = 6;

    localparam logic [15:0] STATUS_RDY = 16'h0040;
    localparam int FULL_COUNT   = 256;
    localparam int ITEM_TARGET  = 1250;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_PCT     = 13;

    typedef enum logic [1:0] {XFER_IDLE, XFER_READ, XFER_WRITE, XFER_IDENT} xfer_mode_t;

    typedef struct packed {
        logic [15:0] rdata;
        logic        drq;
        logic        err;
    } disk_reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic [4:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // drive model
    logic [15:0] disk_words [STORE_WORDS];
    bit          word_written [STORE_WORDS];
    logic [7:0]  tf_count = 8'h00;
    logic [27:0] tf_lba = '0;
    logic [7:0]  tf_select = 8'hE0;
    xfer_mode_t  xfer_mode = XFER_IDLE;
    logic [8:0]  xfer_left = '0;
    logic [7:0]  xfer_word = '0;
    logic        st_drq = 1'b0;
    logic        st_err = 1'b0;
    logic [7:0]  geo_cyl = 8'd16;
    logic [7:0]  geo_heads = 8'd4;
    logic [7:0]  geo_spt = 8'd63;

    disk_reply_t disk_replies[$];
    int          fault_count = 0;
    int          accesses_sent = 0;
    bit          no_gaps = 1'b0;
    int          long_hold_request = 0;
    int          hold_left = 0;
    logic [27:0] filled_base = '0;

    ata_pio_lba28_disk_device_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // drive model
    // ------------------------------------------------------------------
    function automatic int unsigned store_index();
        logic [31:0] a;
        a = {4'h0, tf_lba} * 32'(SECTOR_WORDS) + {24'h0, xfer_word};
        return (a < STORE_WORDS) ? a : 0;
    endfunction

    function automatic logic [15:0] identify_word(input logic [7:0] idx);
        if (idx == ID_WORD_CYLINDERS)
            return {8'h00, geo_cyl};
        if (idx == ID_WORD_HEADS)
            return {8'h00, geo_heads};
        if (idx == ID_WORD_SPT)
            return {8'h00, geo_spt};
        return 16'h0000;
    endfunction

    task automatic go_idle(input logic err);
        xfer_mode = XFER_IDLE;
        xfer_left = '0;
        xfer_word = '0;
        st_drq = 1'b0;
        st_err = err;
    endtask

    task automatic start_transfer(input xfer_mode_t mode);
        int unsigned span;
        span = (tf_count == 8'h00) ? FULL_COUNT : tf_count;
        if (32'(tf_lba) + span > 32'(DISK_SECTORS))
        begin
            go_idle(1'b1);
            return;
        end
        xfer_mode = mode;
        xfer_left = 9'(span);
        xfer_word = '0;
        st_drq = 1'b1;
        st_err = 1'b0;
    endtask

    task automatic run_command(input logic [7:0] cmd);
        case (cmd)
            CMD_FLUSH:
            begin
                if (xfer_mode != XFER_WRITE)
                    go_idle(1'b0);
            end
            CMD_READ:  start_transfer(XFER_READ);
            CMD_WRITE: start_transfer(XFER_WRITE);
            CMD_IDENT:
            begin
                xfer_mode = XFER_IDENT;
                xfer_left = 9'd1;
                xfer_word = '0;
                st_drq = 1'b1;
                st_err = 1'b0;
            end
            default:   go_idle(1'b1);
        endcase
    endtask

    task automatic advance_word();
        xfer_word = xfer_word + 8'd1;
        if (xfer_word != 8'd0)
            return;
        if (xfer_mode != XFER_IDENT)
            tf_lba = tf_lba + 28'd1;
        if (xfer_left != 0)
            xfer_left = xfer_left - 9'd1;
        if (xfer_left == 0)
            go_idle(1'b0);
    endtask

    task automatic predict_bus_access(input logic op, input logic [3:0] off,
                                      input logic [15:0] wd);
        disk_reply_t r;
        logic [7:0]  b;
        int unsigned idx;
        b = wd[7:0];
        r.rdata = '0;
        if (op == ACC_WRITE)
        begin
            case (off)
                REG_PIO_WORD:
                begin
                    if (xfer_mode == XFER_WRITE && st_drq)
                    begin
                        idx = store_index();
                        disk_words[idx] = wd;
                        word_written[idx] = 1'b1;
                        advance_word();
                    end
                end
                REG_COUNT:      tf_count = b;
                REG_LBA_LO:     tf_lba[7:0] = b;
                REG_LBA_BYTE1:  tf_lba[15:8] = b;
                REG_LBA_HI:     tf_lba[23:16] = b;
                REG_SELECT:
                begin
                    tf_select = b;
                    tf_lba[27:24] = b[3:0];
                end
                REG_CMD_STATUS: run_command(b);
                default: ;
            endcase
        end
        else
        begin
            case (off)
                REG_PIO_WORD:
                begin
                    if (xfer_mode == XFER_READ && st_drq)
                    begin
                        r.rdata = disk_words[store_index()];
                        advance_word();
                    end
                    else if (xfer_mode == XFER_IDENT && st_drq)
                    begin
                        r.rdata = identify_word(xfer_word);
                        advance_word();
                    end
                end
                REG_COUNT:     r.rdata = {8'h00, tf_count};
                REG_LBA_LO:    r.rdata = {8'h00, tf_lba[7:0]};
                REG_LBA_BYTE1: r.rdata = {8'h00, tf_lba[15:8]};
                REG_LBA_HI:    r.rdata = {8'h00, tf_lba[23:16]};
                REG_SELECT:    r.rdata = {8'h00, tf_select};
                REG_CMD_STATUS, REG_ALT_STATUS:
                    r.rdata = STATUS_RDY | {12'h000, st_drq, 2'b00, st_err};
                default: ;
            endcase
        end
        r.drq = st_drq;
        r.err = st_err;
        disk_replies.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // stimulus plumbing
    // ------------------------------------------------------------------
    task automatic send_access(input logic op, input logic [3:0] off, input logic [15:0] wd);
        logic [3:0] eff_off;
        eff_off = off;
        // never read a store word that was never written
        if (op == ACC_READ && off == REG_PIO_WORD && xfer_mode == XFER_READ && st_drq
            && !word_written[store_index()])
            eff_off = REG_ALT_STATUS;
        if (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= wd;
        s_tuser <= {eff_off, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accesses_sent++;
        predict_bus_access(op, eff_off, wd);
    endtask

    task automatic issue_command(input logic [7:0] cmd);
        send_access(ACC_WRITE, REG_CMD_STATUS, {8'($urandom), cmd});
    endtask

    task automatic program_taskfile(input logic [27:0] lba, input logic [7:0] count);
        send_access(ACC_WRITE, REG_COUNT, {8'($urandom), count});
        send_access(ACC_WRITE, REG_LBA_LO, {8'($urandom), lba[7:0]});
        send_access(ACC_WRITE, REG_LBA_BYTE1, {8'($urandom), lba[15:8]});
        send_access(ACC_WRITE, REG_LBA_HI, {8'($urandom), lba[23:16]});
        send_access(ACC_WRITE, REG_SELECT, {8'($urandom), 4'($urandom), lba[27:24]});
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (disk_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [7:0] cyl, input logic [7:0] heads,
                                input logic [7:0] spt);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CYLINDERS;
        cfg_wdata <= cyl;
        @(posedge clk);
        cfg_index <= CFG_HEADS;
        cfg_wdata <= heads;
        @(posedge clk);
        cfg_index <= CFG_SPT;
        cfg_wdata <= spt;
        @(posedge clk);
        cfg_we <= 1'b0;
        geo_cyl = cyl;
        geo_heads = heads;
        geo_spt = spt;
    endtask

    function automatic logic [7:0] random_unknown_cmd();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CMD_READ || c == CMD_WRITE || c == CMD_FLUSH || c == CMD_IDENT);
        return c;
    endfunction

    // status, LBA readback or a taskfile write in the middle of a transfer
    task automatic side_access();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            send_access(ACC_READ, $urandom_range(1) ? REG_CMD_STATUS : REG_ALT_STATUS,
                        16'($urandom));
        else if (pick < 70)
            send_access(ACC_READ, 4'($urandom_range(REG_LBA_HI, REG_LBA_LO)), 16'($urandom));
        else if (pick < 90)
            send_access(ACC_WRITE, REG_LBA_LO, {8'($urandom), 8'($urandom_range(DISK_SECTORS - 1))});
        else
            send_access(ACC_WRITE, REG_LBA_HI, 16'($urandom));
    endtask

    task automatic end_burst();
        case ($urandom_range(5))
            0: issue_command(CMD_FLUSH);
            1: issue_command(random_unknown_cmd());
            2: issue_command(CMD_IDENT);
            3: send_access(ACC_READ, REG_CMD_STATUS, 16'($urandom));
            4: issue_command(CMD_WRITE);
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_taskfile_registers();
        send_access(ACC_WRITE, REG_COUNT, 16'hFFFF);
        send_access(ACC_WRITE, REG_LBA_LO, 16'hFFFF);
        send_access(ACC_WRITE, REG_SELECT, 16'h00FF);
        send_access(ACC_WRITE, REG_FEATURES, 16'hFFFF);
        send_access(ACC_WRITE, REG_UNMAPPED, 16'hFFFF);
        send_access(ACC_WRITE, REG_PIO_WORD, 16'hFFFF);
        send_access(ACC_READ, REG_LBA_LO, 16'h0000);
        send_access(ACC_READ, REG_SELECT, 16'h0000);
        send_access(ACC_READ, REG_UNMAPPED, 16'h0000);
        send_access(ACC_READ, REG_PIO_WORD, 16'h0000);
        send_access(ACC_READ, REG_ALT_STATUS, 16'hFFFF);
    endtask

    task automatic test_command_cases();
        int i;
        send_access(ACC_WRITE, REG_SELECT, {8'h00, 8'hE0});
        send_access(ACC_WRITE, REG_LBA_LO, 16'h0000);
        issue_command(CMD_READ);
        issue_command(CMD_UNKNOWN);
        issue_command(CMD_FLUSH);
        send_access(ACC_WRITE, REG_COUNT, 16'h0000);
        issue_command(CMD_READ);
        send_access(ACC_WRITE, REG_COUNT, 16'h0002);
        issue_command(CMD_WRITE);
        send_access(ACC_WRITE, REG_PIO_WORD, 16'h0000);
        send_access(ACC_WRITE, REG_PIO_WORD, 16'hFFFF);
        issue_command(CMD_FLUSH);
        send_access(ACC_WRITE, REG_LBA_LO, 16'h0001);
        send_access(ACC_WRITE, REG_PIO_WORD, 16'($urandom));
        issue_command(CMD_IDENT);
        for (i = 0; i < 4; i++)
            send_access(ACC_READ, REG_PIO_WORD, 16'h0000);
        send_access(ACC_WRITE, REG_LBA_LO, 16'h0000);
        issue_command(CMD_READ);
        for (i = 0; i < 3; i++)
            send_access(ACC_READ, REG_PIO_WORD, 16'h0000);
        issue_command(CMD_FLUSH);
        send_access(ACC_READ, REG_CMD_STATUS, 16'h0000);
    endtask

    task automatic test_geometry_settings();
        logic [7:0] cyl, heads, spt;
        int k, i;
        for (k = 0; k < 4; k++)
        begin
            cyl = 8'($urandom);
            heads = 8'($urandom);
            spt = 8'($urandom);
            if (k == 0)
            begin
                cyl = 8'h00;
                heads = 8'h00;
                spt = 8'h00;
            end
            else if (k == 1)
            begin
                cyl = 8'hFF;
                heads = 8'hFF;
                spt = 8'hFF;
            end
            else if (k == 2)
            begin
                cyl = 8'hFF;
                heads = 8'h00;
            end
            wait_drain();
            set_geometry(cyl, heads, spt);
            issue_command(CMD_IDENT);
            for (i = 0; i < 8; i++)
                send_access(ACC_READ, REG_PIO_WORD, 16'($urandom));
            issue_command(CMD_FLUSH);
        end
    endtask

    // two whole sectors written, then the second read back, with no idle cycles
    task automatic test_full_sectors();
        int i;
        no_gaps = 1'b1;
        filled_base = 28'($urandom_range(DISK_SECTORS - 2));
        program_taskfile(filled_base, 8'd2);
        issue_command(CMD_WRITE);
        for (i = 0; i < 2 * SECTOR_WORDS; i++)
        begin
            if (i == SECTOR_WORDS)
                send_access(ACC_READ, REG_LBA_LO, 16'h0000);
            send_access(ACC_WRITE, REG_PIO_WORD, 16'($urandom));
        end
        send_access(ACC_READ, REG_CMD_STATUS, 16'h0000);
        program_taskfile(filled_base + 28'd1, 8'd1);
        issue_command(CMD_READ);
        for (i = 0; i < SECTOR_WORDS; i++)
            send_access(ACC_READ, REG_PIO_WORD, 16'h0000);
        send_access(ACC_READ, REG_LBA_LO, 16'h0000);
        no_gaps = 1'b0;
    endtask

    task automatic test_output_stall();
        int i;
        long_hold_request = LONG_HOLD;
        for (i = 0; i < 40; i++)
            send_access(1'($urandom), 4'($urandom_range(REG_ALT_STATUS, REG_COUNT)),
                        16'($urandom));
    endtask

    task automatic test_random_traffic();
        int pick, n, i;
        logic [27:0] lba;
        while (accesses_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                lba = ($urandom_range(9) == 0) ? 28'($urandom)
                                               : 28'($urandom_range(DISK_SECTORS - 1));
                program_taskfile(lba, 8'($urandom_range(3)));
                issue_command(CMD_WRITE);
                n = $urandom_range(48, 1);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(99) < 85)
                        send_access(ACC_WRITE, REG_PIO_WORD, 16'($urandom));
                    else
                        side_access();
                end
                end_burst();
            end
            else if (pick < 60)
            begin
                lba = ($urandom_range(9) < 7) ? filled_base + 28'($urandom_range(1))
                                              : 28'($urandom_range(DISK_SECTORS - 1));
                program_taskfile(lba, 8'($urandom_range(3)));
                issue_command(CMD_READ);
                n = $urandom_range(48, 1);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(99) < 85)
                        send_access(ACC_READ, REG_PIO_WORD, 16'($urandom));
                    else
                        side_access();
                end
                end_burst();
            end
            else if (pick < 75)
            begin
                issue_command(CMD_IDENT);
                n = $urandom_range(12);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(99) < 85)
                        send_access(ACC_READ, REG_PIO_WORD, 16'($urandom));
                    else
                        side_access();
                end
                end_burst();
            end
            else
            begin
                n = $urandom_range(6, 1);
                for (i = 0; i < n; i++)
                    send_access(1'($urandom), 4'($urandom), 16'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (long_hold_request != 0)
        begin
            hold_left = long_hold_request;
            long_hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin : reply_check
        disk_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (disk_replies.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected reply: tdata %h", m_tdata);
            end
            else
            begin
                want = disk_replies.pop_front();
                if (m_tdata[15:0] !== want.rdata || m_tdata[16] !== want.drq
                    || m_tdata[17] !== want.err)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("reply mismatch: rdata %h drq %b err %b, expected %h %b %b",
                                 m_tdata[15:0], m_tdata[16], m_tdata[17],
                                 want.rdata, want.drq, want.err);
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_taskfile_registers();
        test_command_cases();
        test_geometry_settings();
        test_full_sectors();
        test_output_stall();
        test_random_traffic();
        wait_drain();
        if (fault_count == 0 && disk_replies.size() == 0)
            $display("ata_pio_lba28_disk_device_unit verification clean");
        else
            $display("ata_pio_lba28_disk_device_unit verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("ata_pio_lba28_disk_device_unit verification failed");
        $finish;
    end

endmodule
